FILE: hw/rtl/beaver_share_multiply_engine_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the share multiply engine.
// ----------------------------------------------------------------------------
`ifndef BEAVER_SHARE_MULTIPLY_ENGINE_MACROS_SVH
`define BEAVER_SHARE_MULTIPLY_ENGINE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BSME_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define BSME_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bsme_pkg.sv
// ----------------------------------------------------------------------------
// bsme_pkg
// Types, codes and helpers shared by the share multiply engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bsme_pkg;

    localparam int DATA_W    = 64;
    localparam int HALF_W    = DATA_W / 2;
    localparam int WIDTH_W   = 7;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 1;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef logic [DATA_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_MUL    = 3'd0,
        OP_CROSS  = 3'd1,
        OP_VMUL   = 3'd2,
        OP_FMULT  = 3'd3,
        OP_SELECT = 3'd4,
        OP_OSWAP  = 3'd5
    } op_t;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTY = 1'd1;

    localparam word_t MASK_RESET = '1;

    typedef struct packed {
        logic              kind;
        logic [OP_W-1:0]   operation;
        word_t             share_a;
        word_t             share_b;
        logic              flag_share;
        word_t             trip_x;
        word_t             trip_y;
        word_t             trip_z;
        word_t             peer_open_x;
        word_t             peer_open_y;
    } in_item_t;

    // r0: blinded x on start, addend on finish; r1: blinded y or flag-op a+b, else 0
    typedef struct packed {
        logic  fin;
        logic  err;
        logic  wen;
        word_t r0;
        word_t r1;
        word_t m0a;
        word_t m0b;
        word_t m1a;
        word_t m1b;
        word_t m2a;
        word_t m2b;
    } qent_t;

    function automatic word_t mask_of(input logic [WIDTH_W-1:0] w);
        word_t m;
        if (w == '0)
        begin
            m = '0;
        end
        else if (w >= WIDTH_W'(DATA_W))
        begin
            m = '1;
        end
        else
        begin
            m = (word_t'(1) << w) - word_t'(1);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bsme_front.sv
// ----------------------------------------------------------------------------
// bsme_front
// Accepts items, holds the pending start and builds the work entry for the
// back end: blinded values on start, multiplier operands on finish.
// ----------------------------------------------------------------------------
`default_nettype none
`include "beaver_share_multiply_engine_macros.svh"

module bsme_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bsme_pkg::in_item_t item,
    input  wire logic              push,
    input  wire logic              q_full,
    input  wire logic              party,
    output logic                   enq,
    output bsme_pkg::qent_t        ent
);
    import bsme_pkg::*;

    logic              accept;
    logic              fin_accept;
    logic              flag_in;
    word_t             base_in;
    word_t             v_in;
    word_t             sv_in;
    logic              held_flag_op;

    logic              pending_valid_reg;
    logic [OP_W-1:0]   pending_op_reg;
    word_t             held_a_reg;
    word_t             held_b_reg;
    logic              held_flag_reg;
    word_t             held_tx_reg;
    word_t             held_ty_reg;
    word_t             held_tz_reg;
    word_t             held_v_reg;
    word_t             held_sv_reg;

    assign accept     = push && !q_full;
    assign enq        = accept;
    assign fin_accept = accept && (item.kind == KIND_FINISH);

    assign flag_in = (item.operation == OP_FMULT) || (item.operation == OP_SELECT)
                  || (item.operation == OP_OSWAP);
    assign base_in = (item.operation == OP_FMULT) ? '0 : item.share_a;
    assign v_in    = item.share_b - base_in;
    assign sv_in   = item.flag_share ? (base_in - item.share_b) : v_in;

    assign held_flag_op = (pending_op_reg == OP_FMULT) || (pending_op_reg == OP_SELECT)
                       || (pending_op_reg == OP_OSWAP);

    always_comb
    begin
        ent = '0;
        if (item.kind == KIND_START)
        begin
            priority if (item.operation == OP_VMUL)
            begin
                ent.r0 = item.share_a + item.trip_x;
            end
            else if (flag_in)
            begin
                ent.r0 = sv_in + item.trip_x;
                ent.r1 = word_t'(item.flag_share) + item.trip_y;
            end
            else
            begin
                ent.r0 = item.share_a + item.trip_x;
                ent.r1 = item.share_b + item.trip_y;
            end
        end
        else
        begin
            ent.fin = 1'b1;
            priority if (!pending_valid_reg)
            begin
                ent.err = 1'b1;
            end
            else if (pending_op_reg == OP_VMUL)
            begin
                ent.m0a = party ? (word_t'(0) - held_tx_reg) : held_a_reg;
                ent.m0b = item.peer_open_x;
                ent.r0  = held_tz_reg;
            end
            else if (held_flag_op)
            begin
                ent.m0a = held_sv_reg;
                ent.m0b = item.peer_open_y;
                ent.m1a = held_ty_reg;
                ent.m1b = item.peer_open_x;
                ent.r0  = held_tz_reg + (held_flag_reg ? held_v_reg : '0)
                        + ((pending_op_reg == OP_FMULT) ? '0 : held_a_reg);
                ent.r1  = held_a_reg + held_b_reg;
                ent.wen = (pending_op_reg == OP_OSWAP);
            end
            else
            begin
                ent.m0a = held_a_reg;
                ent.m0b = item.peer_open_y;
                ent.m1a = held_ty_reg;
                ent.m1b = item.peer_open_x;
                ent.m2a = (pending_op_reg == OP_CROSS) ? '0 : held_a_reg;
                ent.m2b = held_b_reg;
                ent.r0  = held_tz_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg <= 1'b0;
            pending_op_reg    <= '0;
            held_a_reg        <= '0;
            held_b_reg        <= '0;
            held_flag_reg     <= 1'b0;
            held_tx_reg       <= '0;
            held_ty_reg       <= '0;
            held_tz_reg       <= '0;
            held_v_reg        <= '0;
            held_sv_reg       <= '0;
        end
        else if (accept)
        begin
            if (item.kind == KIND_START)
            begin
                pending_valid_reg <= 1'b1;
                pending_op_reg    <= item.operation;
                held_a_reg        <= item.share_a;
                held_b_reg        <= item.share_b;
                held_flag_reg     <= item.flag_share;
                held_tx_reg       <= item.trip_x;
                held_ty_reg       <= item.trip_y;
                held_tz_reg       <= item.trip_z;
                held_v_reg        <= v_in;
                held_sv_reg       <= sv_in;
            end
            else
            begin
                pending_valid_reg <= 1'b0;
            end
        end
    end

    `BSME_ASSERT_NXT(a_fin_clears, fin_accept, !pending_valid_reg, "start survived finish")

endmodule

`default_nettype wire

FILE: hw/rtl/bsme_queue.sv
// ----------------------------------------------------------------------------
// bsme_queue
// Short register queue of work entries between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "beaver_share_multiply_engine_macros.svh"

module bsme_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            enq,
    input  wire bsme_pkg::qent_t ent_in,
    input  wire logic            deq,
    output bsme_pkg::qent_t      ent_out,
    output logic                 full,
    output logic                 empty
);
    import bsme_pkg::*;

    qent_t                mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign ent_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({enq, deq})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem_reg[wr_ptr_reg] <= ent_in;
        end
    end

    `BSME_ASSERT_IMP(a_q_no_overflow, enq, !full, "queue written while full")
    `BSME_ASSERT_IMP(a_q_no_underflow, deq, count_reg != '0, "queue read while empty")

endmodule

`default_nettype wire

FILE: hw/rtl/bsme_back.sv
// ----------------------------------------------------------------------------
// bsme_back
// Carries out queued entries: three 32x32 multipliers step through the
// partial products of three 64-bit products, then sum, mask and hold result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "beaver_share_multiply_engine_macros.svh"

module bsme_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire bsme_pkg::qent_t ent,
    output logic                 deq,
    input  wire bsme_pkg::word_t mask,
    input  wire logic            pop,
    output logic                 empty,
    output logic                 is_final,
    output bsme_pkg::word_t      blind_out_x,
    output bsme_pkg::word_t      blind_out_y,
    output bsme_pkg::word_t      share_z,
    output bsme_pkg::word_t      share_w,
    output logic                 error
);
    import bsme_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM, S_OUT} state_t;

    localparam logic [1:0] STEP_LL   = 2'd0;
    localparam logic [1:0] STEP_LH   = 2'd1;
    localparam logic [1:0] STEP_HL   = 2'd2;
    localparam logic [1:0] STEP_LAST = 2'd3;

    function automatic word_t mul_part(input word_t a, input word_t b, input logic [1:0] step);
        logic [HALF_W-1:0] ah;
        logic [HALF_W-1:0] bh;
        ah = (step == STEP_HL) ? a[DATA_W-1:HALF_W] : a[HALF_W-1:0];
        bh = (step == STEP_LH) ? b[DATA_W-1:HALF_W] : b[HALF_W-1:0];
        return ah * bh;
    endfunction

    function automatic word_t part_term(input word_t p, input logic full_term);
        return full_term ? p : {p[HALF_W-1:0], HALF_W'(0)};
    endfunction

    state_t      state_reg, state_next;
    logic [1:0]  step_reg, step_next;
    qent_t       ent_reg, ent_next;
    word_t       pr0_reg, pr0_next;
    word_t       pr1_reg, pr1_next;
    word_t       pr2_reg, pr2_next;
    word_t       acc0_reg, acc0_next;
    word_t       acc1_reg, acc1_next;
    word_t       acc2_reg, acc2_next;
    word_t       z_reg, z_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_fin_reg, out_fin_next;
    word_t       out_bx_reg, out_bx_next;
    word_t       out_by_reg, out_by_next;
    word_t       out_z_reg, out_z_next;
    word_t       out_w_reg, out_w_next;
    logic        out_err_reg, out_err_next;
    logic        load_out;
    logic        take;
    logic        full_term;
    logic        mul_last;

    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || pop);
    assign take      = !q_empty && ((state_reg == S_IDLE) || load_out);
    assign deq       = take;
    assign full_term = (step_reg == STEP_LH);
    assign mul_last  = (state_reg == S_MUL) && (step_reg == STEP_LAST);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        ent_next       = ent_reg;
        pr0_next       = pr0_reg;
        pr1_next       = pr1_reg;
        pr2_next       = pr2_reg;
        acc0_next      = acc0_reg;
        acc1_next      = acc1_reg;
        acc2_next      = acc2_reg;
        z_next         = z_reg;
        out_valid_next = out_valid_reg && !pop;
        out_fin_next   = out_fin_reg;
        out_bx_next    = out_bx_reg;
        out_by_next    = out_by_reg;
        out_z_next     = out_z_reg;
        out_w_next     = out_w_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_MUL:
            begin
                if (step_reg != STEP_LAST)
                begin
                    pr0_next = mul_part(ent_reg.m0a, ent_reg.m0b, step_reg);
                    pr1_next = mul_part(ent_reg.m1a, ent_reg.m1b, step_reg);
                    pr2_next = mul_part(ent_reg.m2a, ent_reg.m2b, step_reg);
                end
                if (step_reg != STEP_LL)
                begin
                    acc0_next = acc0_reg + part_term(pr0_reg, full_term);
                    acc1_next = acc1_reg + part_term(pr1_reg, full_term);
                    acc2_next = acc2_reg + part_term(pr2_reg, full_term);
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                z_next     = acc0_reg - acc1_reg + acc2_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_fin_next   = ent_reg.fin;
                    out_err_next   = ent_reg.err;
                    out_bx_next    = ent_reg.fin ? '0 : (ent_reg.r0 & mask);
                    out_by_next    = ent_reg.fin ? '0 : (ent_reg.r1 & mask);
                    out_z_next     = ent_reg.fin ? (z_reg & mask) : '0;
                    out_w_next     = (ent_reg.fin && ent_reg.wen)
                                   ? ((ent_reg.r1 - z_reg) & mask) : '0;
                    state_next     = S_IDLE;
                end
            end
        endcase

        if (take)
        begin
            ent_next   = ent;
            step_next  = STEP_LL;
            acc0_next  = ent.r0;
            acc1_next  = '0;
            acc2_next  = '0;
            state_next = ent.fin ? S_MUL : S_OUT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STEP_LL;
            ent_reg       <= '0;
            pr0_reg       <= '0;
            pr1_reg       <= '0;
            pr2_reg       <= '0;
            acc0_reg      <= '0;
            acc1_reg      <= '0;
            acc2_reg      <= '0;
            z_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_fin_reg   <= 1'b0;
            out_bx_reg    <= '0;
            out_by_reg    <= '0;
            out_z_reg     <= '0;
            out_w_reg     <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ent_reg       <= ent_next;
            pr0_reg       <= pr0_next;
            pr1_reg       <= pr1_next;
            pr2_reg       <= pr2_next;
            acc0_reg      <= acc0_next;
            acc1_reg      <= acc1_next;
            acc2_reg      <= acc2_next;
            z_reg         <= z_next;
            out_valid_reg <= out_valid_next;
            out_fin_reg   <= out_fin_next;
            out_bx_reg    <= out_bx_next;
            out_by_reg    <= out_by_next;
            out_z_reg     <= out_z_next;
            out_w_reg     <= out_w_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign is_final    = out_fin_reg;
    assign blind_out_x = out_bx_reg;
    assign blind_out_y = out_by_reg;
    assign share_z     = out_z_reg;
    assign share_w     = out_w_reg;
    assign error       = out_err_reg;

    `BSME_ASSERT_NXT(a_mul_to_sum, mul_last, state_reg == S_SUM, "multiply did not end in sum")
    `BSME_ASSERT_IMP(a_out_src, $rose(out_valid_reg), $past(state_reg) == S_OUT, "stray result")

endmodule

`default_nettype wire

FILE: hw/rtl/beaver_share_multiply_engine.sv
// ----------------------------------------------------------------------------
// beaver_share_multiply_engine
// One party's side of Beaver-triple share multiplication mod 2^width_bits.
// Input channel: push/full; an item transfers when push is high and full low.
// A start item (kind 0) stores operation, shares and triple and returns the
// blinded values; a finish item (kind 1) returns the result share(s), or an
// error result when no start is pending.
// Result channel: empty/pop; the oldest result sits on the ports while empty
// is low and transfers when pop is high.
// Throughput: one start per cycle while results are popped and no finish is
// busy; one finish at a time, the three 32x32 multipliers stepping over three
// partial products per 64-bit product. A stalled receiver holds the result; a
// 2-entry queue keeps taking items. Reset clears pending state and the queue;
// width_bits is 64, party_index 0. The user must write configuration
// (cfg_we/cfg_index/cfg_data) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module beaver_share_multiply_engine (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bsme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bsme_pkg::WIDTH_W-1:0]      cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              kind,
    input  wire logic [bsme_pkg::OP_W-1:0]         operation,
    input  wire logic [bsme_pkg::DATA_W-1:0]       share_a,
    input  wire logic [bsme_pkg::DATA_W-1:0]       share_b,
    input  wire logic                              flag_share,
    input  wire logic [bsme_pkg::DATA_W-1:0]       trip_x,
    input  wire logic [bsme_pkg::DATA_W-1:0]       trip_y,
    input  wire logic [bsme_pkg::DATA_W-1:0]       trip_z,
    input  wire logic [bsme_pkg::DATA_W-1:0]       peer_open_x,
    input  wire logic [bsme_pkg::DATA_W-1:0]       peer_open_y,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic                                   is_final,
    output logic [bsme_pkg::DATA_W-1:0]            blind_out_x,
    output logic [bsme_pkg::DATA_W-1:0]            blind_out_y,
    output logic [bsme_pkg::DATA_W-1:0]            share_z,
    output logic [bsme_pkg::DATA_W-1:0]            share_w,
    output logic                                   error
);
    import bsme_pkg::*;

    word_t     mask_reg, mask_next;
    logic      party_reg, party_next;
    in_item_t  item;
    logic      q_enq;
    qent_t     q_ent_in;
    logic      q_deq;
    qent_t     q_ent_out;
    logic      q_full;
    logic      q_empty;

    always_comb
    begin
        mask_next  = mask_reg;
        party_next = party_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH: mask_next  = mask_of(cfg_data);
                REG_PARTY: party_next = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= MASK_RESET;
            party_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= mask_next;
            party_reg <= party_next;
        end
    end

    always_comb
    begin
        item.kind        = kind;
        item.operation   = operation;
        item.share_a     = share_a;
        item.share_b     = share_b;
        item.flag_share  = flag_share;
        item.trip_x      = trip_x;
        item.trip_y      = trip_y;
        item.trip_z      = trip_z;
        item.peer_open_x = peer_open_x;
        item.peer_open_y = peer_open_y;
    end

    assign full = q_full;

    bsme_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .push   (push),
        .q_full (q_full),
        .party  (party_reg),
        .enq    (q_enq),
        .ent    (q_ent_in)
    );

    bsme_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (q_enq),
        .ent_in  (q_ent_in),
        .deq     (q_deq),
        .ent_out (q_ent_out),
        .full    (q_full),
        .empty   (q_empty)
    );

    bsme_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .ent         (q_ent_out),
        .deq         (q_deq),
        .mask        (mask_reg),
        .pop         (pop),
        .empty       (empty),
        .is_final    (is_final),
        .blind_out_x (blind_out_x),
        .blind_out_y (blind_out_y),
        .share_z     (share_z),
        .share_w     (share_w),
        .error       (error)
    );

endmodule

`default_nettype wire
